@@ rtl/dcf_pkg.sv @@
// Shared types and constants for the divisor count filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int NUM_W           = 16;   // width of value and number fields
    localparam int CNT_W           = 8;    // width of a divisor count
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 8;

    localparam int SET_DEPTH_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_ALL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REF    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd1;

    localparam logic [CNT_W-1:0] TARGET_RST = 8'd2;
    localparam logic [CNT_W-1:0] CNT_SAT    = 8'hFF;

    // One held entry of a set
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] cnt;
    } t_entry;

endpackage

@@ rtl/dcf_divmod.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on dcf_pkg for the default width.
`timescale 1ns / 1ps

module dcf_divmod import dcf_pkg::*; #(
    parameter int VW = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(VW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_step;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvd;
    logic [VW-1:0] r_dsr;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[VW-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= CW'(VW - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/dcf_store.sv @@
// Set store: one write port, one read port with registered read data.
// Depends on dcf_pkg for the entry type.
`timescale 1ns / 1ps

module dcf_store import dcf_pkg::*; #(
    parameter int DEPTH = SET_DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

@@ rtl/divisor_count_filter.sv @@
// Divisor count filter top level: trial-division sequencer, filter control
// and output register. Depends on dcf_pkg, dcf_divmod and dcf_store.
`timescale 1ns / 1ps

// Usage
// - Input channel (i_valid/o_ready): one number per item, i_last_of_set marks
//   the end of a set. One item is worked on at a time; o_ready is high only
//   while the block is waiting for a new item.
// - Output channel (o_valid/i_ready): number, its divisor count and a last
//   flag on the final result caused by an input item. A registered output
//   stage holds a result while the receiver stalls; the block stalls behind
//   it only when a further result is ready to go.
// - Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 mode,
//   index 1 target count; other indexes are ignored. Write only when idle.
// - Trial division: each candidate divisor d (d*d <= value) costs a test step plus
//   a bit-serial remainder over the full VALUE_WIDTH, so the time per item
//   grows with floor(sqrt(value)); the serial remainder unit dominates it.
// - Maximum-set mode: at end of set each held entry in the store is read,
//   then checked, and emitted if it holds the maximum (waiting on any stall).
// - Reset (synchronous, active low) clears mode to list-all, target to 2, and
//   empties the set state. The store itself is not cleared: only entries below
//   the fill level are ever read.

module divisor_count_filter import dcf_pkg::*; #(
    parameter int SET_DEPTH   = SET_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [NUM_W-1:0]      i_value,
    input  logic                  i_last_of_set,
    // result items
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [NUM_W-1:0]      o_number,
    output logic [CNT_W-1:0]      o_divisor_count,
    output logic                  o_last,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int FW = $clog2(SET_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TEST   = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_SW_RD  = 7'b0100000,
        S_SW_CHK = 7'b1000000
    } t_state;

    // control state
    t_state              r_state,    n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [CNT_W-1:0]    r_target;
    logic [FW-1:0]       r_fill,     n_fill;
    logic [CNT_W-1:0]    r_max,      n_max;
    logic [CNT_W-1:0]    r_ref,      n_ref;
    logic                r_seen,     n_seen;
    logic                r_out_valid, n_out_valid;

    // working registers
    logic [VW-1:0]       r_val,      n_val;
    logic                r_end,      n_end;
    logic [VW-1:0]       r_d,        n_d;
    logic [VW+1:0]       r_sq,       n_sq;
    logic [CNT_W-1:0]    r_cnt,      n_cnt;
    logic [AW-1:0]       r_last_idx, n_last_idx;
    logic [AW-1:0]       r_idx,      n_idx;
    logic [NUM_W-1:0]    r_out_num,  n_out_num;
    logic [CNT_W-1:0]    r_out_cnt,  n_out_cnt;
    logic                r_out_last, n_out_last;

    logic [31:0]         in_ext;
    logic [VW-1:0]       val_in;
    logic [31:0]         val_ext;
    logic                out_free;
    logic [CNT_W:0]      cnt_sum;
    logic                sw_match;
    logic                sw_adv;

    logic                div_start;
    logic                div_done;
    logic [VW-1:0]       div_rem;

    logic                wr_en;
    logic                rd_en;
    t_entry              wr_entry;
    t_entry              rd_entry;

    // low VALUE_WIDTH bits of the item are examined
    assign in_ext  = {16'b0, i_value};
    assign val_in  = in_ext[VW-1:0];
    assign val_ext = 32'(r_val);

    assign out_free = !r_out_valid || i_ready;
    assign cnt_sum  = {1'b0, r_cnt} + ((r_sq == {2'b0, r_val}) ? 9'd1 : 9'd2);

    assign wr_entry.num = val_ext[NUM_W-1:0];
    assign wr_entry.cnt = r_cnt;

    assign sw_match = (rd_entry.cnt == r_max);
    assign sw_adv   = !sw_match || out_free;

    dcf_divmod #(.VW(VW)) u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_val),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    dcf_store #(.DEPTH(SET_DEPTH), .AW(AW)) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_fill[AW-1:0]),
        .i_wr_data  (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_idx),
        .o_rd_data  (rd_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_max       = r_max;
        n_ref       = r_ref;
        n_seen      = r_seen;
        n_val       = r_val;
        n_end       = r_end;
        n_d         = r_d;
        n_sq        = r_sq;
        n_cnt       = r_cnt;
        n_last_idx  = r_last_idx;
        n_idx       = r_idx;
        n_out_num   = r_out_num;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val   = val_in;
                    n_end   = i_last_of_set;
                    n_d     = VW'(1);
                    n_sq    = (VW + 2)'(1);
                    n_cnt   = '0;
                    // zero has no divisors: skip the trial loop
                    n_state = (val_in == '0) ? S_DECIDE : S_TEST;
                end
            end
            S_TEST: begin
                if (r_sq > {2'b0, r_val}) begin
                    n_state = S_DECIDE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_cnt = cnt_sum[CNT_W] ? CNT_SAT : cnt_sum[CNT_W-1:0];
                    end
                    n_d     = r_d + 1'b1;
                    n_sq    = r_sq + {1'b0, r_d, 1'b1};   // (d+1)^2 = d^2 + 2d + 1
                    n_state = S_TEST;
                end
            end
            S_DECIDE: begin
                case (r_mode)
                    MODE_ALL: begin
                        n_state = S_EMIT;
                    end
                    MODE_TARGET: begin
                        n_state = (r_cnt == r_target) ? S_EMIT : S_IDLE;
                    end
                    MODE_MAX: begin
                        if (r_fill < FW'(SET_DEPTH)) begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + 1'b1;
                            // newest entry holding the maximum gets the last flag
                            if (r_cnt >= r_max) begin
                                n_max      = r_cnt;
                                n_last_idx = r_fill[AW-1:0];
                            end
                        end
                        n_idx   = '0;
                        n_state = r_end ? S_SW_RD : S_IDLE;
                    end
                    default: begin
                        if (!r_seen) begin
                            n_ref   = r_cnt;
                            n_seen  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = (r_cnt == r_ref) ? S_EMIT : S_IDLE;
                        end
                    end
                endcase
                // end of set; maximum-set mode clears after its sweep
                if (r_end && (r_mode != MODE_MAX)) begin
                    n_fill = '0;
                    n_max  = '0;
                    n_seen = 1'b0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = val_ext[NUM_W-1:0];
                    n_out_cnt   = r_cnt;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SW_RD: begin
                rd_en   = 1'b1;
                n_state = S_SW_CHK;
            end
            S_SW_CHK: begin
                // read data holds while waiting on the output stage
                if (sw_match && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = rd_entry.num;
                    n_out_cnt   = rd_entry.cnt;
                    n_out_last  = (r_idx == r_last_idx);
                end
                if (sw_adv) begin
                    if ((FW'(r_idx) + FW'(1)) == r_fill) begin
                        n_fill  = '0;
                        n_max   = '0;
                        n_seen  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SW_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_max       <= '0;
            r_ref       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_max       <= n_max;
            r_ref       <= n_ref;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_end      <= n_end;
        r_d        <= n_d;
        r_sq       <= n_sq;
        r_cnt      <= n_cnt;
        r_last_idx <= n_last_idx;
        r_idx      <= n_idx;
        r_out_num  <= n_out_num;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ALL;
            r_target <= TARGET_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_TARGET: r_target <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_number        = r_out_num;
    assign o_divisor_count = r_out_cnt;
    assign o_last          = r_out_last;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for divisor_count_filter: directed table, then random sets
// under random settings, with random sender bursts and receiver stalls.
// Depends on dcf_pkg and the divisor_count_filter RTL.
`timescale 1ns / 1ps

module testbench;
    import dcf_pkg::*;

    // The pause and the end wait cover the block's work on the largest value
    // and the sweep of held entries in maximum-set mode.
    localparam int SETTLE_CYCLES  = 5000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS   = 115;
    localparam int STORE_DEPTH    = SET_DEPTH_DEF;
    localparam int FULL_SET_LEN   = STORE_DEPTH + 6;   // overruns the store
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = REG_TARGET + 1'b1;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_result;

    // One directed item; cnt is only meaningful where typed is set
    // (list-all rows whose count is obvious), otherwise the predictor decides.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  target;
        logic [NUM_W-1:0]  value;
        logic              last;
        logic              typed;
        logic [CNT_W-1:0]  cnt;
    } t_row;

    typedef enum logic [1:0] {RX_ALWAYS, RX_SCATTER, RX_BLOCKS} t_rx_style;

    localparam t_row DIRECTED [23] = '{
        // reset settings: list all, target 2
        '{MODE_ALL,    TARGET_RST, 16'd0,     1'b1, 1'b1, 8'd0},
        '{MODE_ALL,    TARGET_RST, 16'd1,     1'b0, 1'b1, 8'd1},
        '{MODE_ALL,    TARGET_RST, 16'd65535, 1'b0, 1'b1, 8'd16},
        '{MODE_ALL,    TARGET_RST, 16'd65521, 1'b1, 1'b1, 8'd2},
        '{MODE_ALL,    TARGET_RST, 16'd55440, 1'b1, 1'b1, 8'd120},
        // match target, target still at its reset value
        '{MODE_TARGET, TARGET_RST, 16'd7,     1'b0, 1'b0, 8'd0},
        '{MODE_TARGET, TARGET_RST, 16'd8,     1'b1, 1'b0, 8'd0},
        // target extremes
        '{MODE_TARGET, 8'd0,       16'd0,     1'b1, 1'b0, 8'd0},
        '{MODE_TARGET, 8'd128,     16'd55440, 1'b1, 1'b0, 8'd0},
        // maximum set: zeros only, then a plain set
        '{MODE_MAX,    8'd128,     16'd0,     1'b0, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd0,     1'b1, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd12,    1'b0, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd6,     1'b0, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd18,    1'b1, 1'b0, 8'd0},
        // reference: single-number set, then a longer one
        '{MODE_REF,    8'd128,     16'd6,     1'b1, 1'b0, 8'd0},
        '{MODE_REF,    8'd128,     16'd6,     1'b0, 1'b0, 8'd0},
        '{MODE_REF,    8'd128,     16'd8,     1'b0, 1'b0, 8'd0},
        '{MODE_REF,    8'd128,     16'd9,     1'b0, 1'b0, 8'd0},
        '{MODE_REF,    8'd128,     16'd10,    1'b1, 1'b0, 8'd0},
        // mode change mid-set: list-all item must leave the store alone
        '{MODE_MAX,    8'd128,     16'd12,    1'b0, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd30,    1'b0, 1'b0, 8'd0},
        '{MODE_ALL,    8'd128,     16'd7,     1'b0, 1'b0, 8'd0},
        '{MODE_MAX,    8'd128,     16'd24,    1'b1, 1'b0, 8'd0}
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [NUM_W-1:0]      i_value         = '0;
    logic                  i_last_of_set   = 1'b0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [NUM_W-1:0]      o_number;
    logic [CNT_W-1:0]      o_divisor_count;
    logic                  o_last;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    divisor_count_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_value         (i_value),
        .i_last_of_set   (i_last_of_set),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_number        (o_number),
        .o_divisor_count (o_divisor_count),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: own copy of the settings and the set state
    // ---------------------------------------------------------------
    logic [MODE_W-1:0] flt_mode   = MODE_ALL;
    logic [CNT_W-1:0]  flt_target = TARGET_RST;
    logic [NUM_W-1:0]  kept_num [STORE_DEPTH];
    logic [CNT_W-1:0]  kept_cnt [STORE_DEPTH];
    int                kept_level = 0;
    logic [CNT_W-1:0]  peak_cnt   = '0;
    logic [CNT_W-1:0]  ref_cnt    = '0;
    logic              ref_taken  = 1'b0;

    t_result qualifying_q [$];   // results still owed by the block
    int      fault_count  = 0;
    int      quiet_cycles = 0;

    // sender and receiver pacing
    int        burst_left = 0;
    bit        steady     = 1'b0;
    t_rx_style rx_style   = RX_ALWAYS;
    logic [7:0] rx_lfsr   = 8'hA5;
    logic [7:0] rx_ctr    = '0;

    // Divisors counted in pairs up to the square root; perfect squares count once.
    function automatic logic [CNT_W-1:0] divisor_tally(input logic [NUM_W-1:0] v);
        int unsigned total;
        int unsigned d;
        total = 0;
        if (v == '0) return '0;
        for (d = 1; d * d <= v; d++) begin
            if (v % d == 0) total += (d * d == v) ? 1 : 2;
        end
        return (total > CNT_SAT) ? CNT_SAT : total[CNT_W-1:0];
    endfunction

    // Runs one accepted number through the filter and queues what it causes.
    // A typed row replaces the prediction with its own result (list-all only).
    task automatic screen_number(input logic [NUM_W-1:0] v, input logic end_flag,
                                 input logic typed, input logic [CNT_W-1:0] typed_cnt);
        logic [CNT_W-1:0] c;
        int               hits;
        int               i;
        c    = divisor_tally(v);
        hits = 0;
        if (typed) begin
            qualifying_q.push_back('{v, typed_cnt, 1'b1});
        end else begin
            case (flt_mode)
                MODE_ALL: begin
                    qualifying_q.push_back('{v, c, 1'b1});
                end
                MODE_TARGET: begin
                    if (c == flt_target) qualifying_q.push_back('{v, c, 1'b1});
                end
                MODE_MAX: begin
                    // numbers past a full store are dropped outright
                    if (kept_level < STORE_DEPTH) begin
                        kept_num[kept_level] = v;
                        kept_cnt[kept_level] = c;
                        kept_level++;
                        if (c > peak_cnt) peak_cnt = c;
                    end
                    if (end_flag) begin
                        for (i = 0; i < kept_level; i++) begin
                            if (kept_cnt[i] == peak_cnt) begin
                                qualifying_q.push_back('{kept_num[i], kept_cnt[i], 1'b0});
                                hits++;
                            end
                        end
                        if (hits > 0) qualifying_q[qualifying_q.size() - 1].last = 1'b1;
                    end
                end
                default: begin
                    if (!ref_taken) begin
                        ref_cnt   = c;
                        ref_taken = 1'b1;
                    end else if (c == ref_cnt) begin
                        qualifying_q.push_back('{v, c, 1'b1});
                    end
                end
            endcase
        end
        // end of set clears the set state in every mode
        if (end_flag) begin
            kept_level = 0;
            peak_cnt   = '0;
            ref_taken  = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Bursts of items with random gaps; no gaps in steady phases.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap        = steady ? 0 : $urandom_range(0, 24);
            burst_left = $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Valid stays up until accepted; the caller lowers it, so back-to-back
    // items never see a low and a high in the same step.
    task automatic send_number(input logic [NUM_W-1:0] v, input logic end_flag,
                               input logic typed, input logic [CNT_W-1:0] typed_cnt);
        pace_sender();
        i_valid       <= 1'b1;
        i_value       <= v;
        i_last_of_set <= end_flag;
        do @(posedge i_clk); while (!o_ready);
        screen_number(v, end_flag, typed, typed_cnt);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_MODE)        flt_mode   = data[MODE_W-1:0];
        else if (idx == REG_TARGET) flt_target = data;
    endtask

    // Everything owed has arrived; then allow for an item that emits nothing.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (qualifying_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only written registers change; every=1 rewrites both and may hit a spare index.
    task automatic change_setting(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] t,
                                  input bit every);
        logic [CFG_DATA_W-MODE_W-1:0] pad;
        logic [CFG_IDX_W-1:0]         spare;
        pad   = (CFG_DATA_W - MODE_W)'($urandom);   // upper data bits of a mode write
        spare = CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI));
        drain_block();
        if (every || m != flt_mode)   write_reg(REG_MODE, {pad, m});
        if (every || t != flt_target) write_reg(REG_TARGET, t);
        if (every && $urandom_range(0, 2) == 0) write_reg(spare, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [NUM_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));   // full range, slow
        if (r < 20) return NUM_W'($urandom_range(0, 1));
        return NUM_W'($urandom_range(2, 240));
    endfunction

    function automatic logic [CNT_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 8'd128;
        return CNT_W'($urandom_range(1, 12));
    endfunction

    // ---------------------------------------------------------------
    // Receiver: stall pattern of its own, style chosen per phase
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_lfsr <= {rx_lfsr[6:0], rx_lfsr[7] ^ rx_lfsr[5] ^ rx_lfsr[4] ^ rx_lfsr[3]};
        rx_ctr  <= rx_ctr + 1'b1;
        case (rx_style)
            RX_ALWAYS:  i_ready <= 1'b1;
            RX_SCATTER: i_ready <= rx_lfsr[0] | rx_lfsr[3];
            default:    i_ready <= (rx_ctr[6:4] != 3'd0);   // stalls while rx_ctr[6:4] is zero
        endcase
    end

    // ---------------------------------------------------------------
    // Result check: each accepted result against the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (qualifying_q.size() == 0) begin
                $display("%0t: unexpected result number %0d count %0d last %0d",
                         $realtime, o_number, o_divisor_count, o_last);
                fault_count++;
            end else begin
                want = qualifying_q.pop_front();
                if (o_number !== want.num) begin
                    $display("%0t: number expected %0d actual %0d",
                             $realtime, want.num, o_number);
                    fault_count++;
                end
                if (o_divisor_count !== want.cnt) begin
                    $display("%0t: divisor_count of %0d expected %0d actual %0d",
                             $realtime, want.num, want.cnt, o_divisor_count);
                    fault_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last of %0d expected %0d actual %0d",
                             $realtime, want.num, want.last, o_last);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("divisor_count_filter regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int               sent;
        int               phase;
        int               n;
        int               k;
        int               set_left;
        bit               full_store;
        logic [MODE_W-1:0] m;
        logic              end_flag;
        logic [NUM_W-1:0]  v;

        sent     = 0;
        phase    = 0;
        set_left = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the first rows run on the reset settings untouched.
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].mode != flt_mode || DIRECTED[r].target != flt_target)
                change_setting(DIRECTED[r].mode, DIRECTED[r].target, 1'b0);
            send_number(DIRECTED[r].value, DIRECTED[r].last,
                        DIRECTED[r].typed, DIRECTED[r].cnt);
        end

        // Random phases.  Sets may run across a phase boundary, so mode changes
        // mid-set happen naturally.  One phase overruns the maximum-set store.
        while (sent < RANDOM_ITEMS) begin
            full_store = (phase == 2);
            m          = full_store ? MODE_MAX : MODE_W'($urandom_range(0, 3));
            change_setting(m, pick_target(), 1'b1);
            steady    = ($urandom_range(0, 3) == 0);
            rx_style <= steady ? RX_ALWAYS : t_rx_style'($urandom_range(0, 2));
            n         = full_store ? FULL_SET_LEN : $urandom_range(4, 12);
            if (full_store) set_left = 0;
            for (k = 0; k < n; k++) begin
                if (full_store) begin
                    v        = NUM_W'($urandom_range(0, 60));
                    end_flag = (k == n - 1);
                end else begin
                    v = pick_value();
                    if (set_left == 0) set_left = $urandom_range(1, 8);
                    set_left--;
                    end_flag = (set_left == 0);
                end
                send_number(v, end_flag, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        // Wait for every owed result, then for any late extra one.
        i_valid <= 1'b0;
        while (qualifying_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && qualifying_q.size() == 0) begin
            $display("divisor_count_filter regression: pass");
        end else begin
            $display("divisor_count_filter regression: fail");
        end
        $finish;
    end

endmodule
